/* hdl/arasc_pkg.sv */
`default_nettype none

package arasc_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   // word select bit of paddr for the cell_kind register
   localparam logic REG_CELL_KIND = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_SMA    = 3'd0,
      KIND_AMA1   = 3'd1,
      KIND_AMA2   = 3'd2,
      KIND_AXA2   = 3'd3,
      KIND_AXA3   = 3'd4,
      KIND_BUFFER = 3'd5,
      KIND_EXACT  = 3'd6
   } cell_kind_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_GT  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic s;
      logic co;
   } cell_out_type;

   function automatic cell_out_type arasc_cell(input cell_kind_type kind, input logic a,
                                               input logic b, input logic c);
      cell_out_type o;
      logic         x;
      x = a ^ b;
      case (kind)
         KIND_SMA: begin
            o.s  = c & ~x;
            o.co = b | (a & c);
         end
         KIND_AMA1: begin
            o.co = b | (a & c);
            o.s  = ~o.co;
         end
         KIND_AMA2: begin
            o.s  = c & (~a | b);
            o.co = a;
         end
         KIND_AXA2: begin
            o.s  = ~x;
            o.co = (a & b) | (x & c);
         end
         KIND_AXA3: begin
            o.s  = c & ~x;
            o.co = (a & b) | (x & c);
         end
         KIND_BUFFER: begin
            o.s  = a;
            o.co = b;
         end
         default: begin
            o.s  = x ^ c;
            o.co = (a & b) | (x & c);
         end
      endcase
      return o;
   endfunction

endpackage

`default_nettype wire

/* hdl/arasc_ripple.sv */
`default_nettype none

module arasc_ripple
   import arasc_pkg::*;
#(
   parameter int unsigned WIDTH = 8
) (
   input  cell_kind_type    kind,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             cin,
   output logic [WIDTH-1:0] sum
);

   logic [WIDTH-1:0] carry;
   cell_out_type     cell_out [WIDTH];

   assign carry[0] = cin;

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      assign cell_out[i] = arasc_cell(kind, a[i], b[i], carry[i]);
      assign sum[i]      = cell_out[i].s;
      if (i < WIDTH - 1) begin : g_link
         assign carry[i+1] = cell_out[i].co;
      end
   end

endmodule

`default_nettype wire

/* hdl/approx_ripple_add_sub_compare.sv */
// Pipeline: an accepted transaction passes the input register, then the result register,
// and shows its result with rsp_valid from the result register.
// Throughput: one transaction per cycle; busy stays low, set by the single ripple pass.
// Reset (synchronous, active high) drops in-flight transactions and sets cell_kind to
// the exact full adder.
`default_nettype none

module approx_ripple_add_sub_compare
   import arasc_pkg::*;
#(
   parameter int unsigned WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [DATA_W-1:0]     req_operand_a,
   input  logic [DATA_W-1:0]     req_operand_b,
   output logic                  rsp_valid,
   output logic [DATA_W-1:0]     rsp_result,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic              csr_write;
   cell_kind_type     cell_kind_ff, cell_kind_in;

   logic              stg_valid_ff;
   logic [CMD_W-1:0]  stg_cmd_ff;
   logic [DATA_W-1:0] stg_a_ff, stg_b_ff;

   logic [WIDTH-1:0]  op_a, op_b, op_b_sel, chain_sum;
   logic              chain_cin;
   logic [DATA_W-1:0] sum_trim;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_result_ff, rsp_result_in;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign csr_write    = psel && penable && pwrite && (paddr[2] == REG_CELL_KIND);
   assign cell_kind_in = csr_write ? cell_kind_type'(pwdata[KIND_W-1:0]) : cell_kind_ff;
   assign prdata       = (paddr[2] == REG_CELL_KIND) ?
                         {{(CSR_DATA_W-KIND_W){1'b0}}, cell_kind_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_kind_ff <= KIND_EXACT;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cell_kind_ff <= cell_kind_in;
         stg_valid_ff <= start && !busy;
         rsp_valid_ff <= stg_valid_ff;
      end
      stg_cmd_ff    <= req_cmd;
      stg_a_ff      <= req_operand_a;
      stg_b_ff      <= req_operand_b;
      rsp_result_ff <= rsp_result_in;
   end

   for (genvar i = 0; i < WIDTH; i++) begin : g_op
      if (i < DATA_W) begin : g_in
         assign op_a[i] = stg_a_ff[i];
         assign op_b[i] = stg_b_ff[i];
      end else begin : g_zero
         assign op_a[i] = 1'b0;
         assign op_b[i] = 1'b0;
      end
   end

   assign chain_cin = (stg_cmd_ff != CMD_ADD);
   assign op_b_sel  = chain_cin ? ~op_b : op_b;

   arasc_ripple #(
      .WIDTH (WIDTH)
   ) u_ripple (
      .kind (cell_kind_ff),
      .a    (op_a),
      .b    (op_b_sel),
      .cin  (chain_cin),
      .sum  (chain_sum)
   );

   for (genvar j = 0; j < DATA_W; j++) begin : g_trim
      if (j < WIDTH) begin : g_bit
         assign sum_trim[j] = chain_sum[j];
      end else begin : g_pad
         assign sum_trim[j] = 1'b0;
      end
   end

   always_comb begin
      case (stg_cmd_ff)
         CMD_ADD: rsp_result_in = sum_trim;
         CMD_SUB: rsp_result_in = sum_trim;
         CMD_GT:  rsp_result_in = {{(DATA_W-1){1'b0}}, ~chain_sum[WIDTH-1]};
         default: rsp_result_in = '0;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

`ifndef SYNTHESIS
   a_start_to_rsp: assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 rsp_valid)
      else $error("accepted transaction gave no result");

   a_no_rsp_without_start: assert property (@(posedge clock) disable iff (reset)
      !start |=> ##1 !rsp_valid)
      else $error("result without a transaction");

   a_gt_is_flag: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && (stg_cmd_ff == CMD_GT)) |=> (rsp_result[DATA_W-1:1] == '0))
      else $error("greater-than result wider than one bit");

   a_bad_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && (stg_cmd_ff != CMD_ADD) && (stg_cmd_ff != CMD_SUB) &&
       (stg_cmd_ff != CMD_GT)) |=> (rsp_result == '0))
      else $error("unused command gave nonzero result");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (cell_kind_ff == $past(pwdata[KIND_W-1:0])))
      else $error("cell_kind write lost");
`endif

endmodule

`default_nettype wire

/* verif/ripple_result_checker.sv */
`timescale 1ns / 100ps

module ripple_result_checker
   import arasc_pkg::*;
#(
   parameter int unsigned WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [DATA_W-1:0]     req_operand_a,
   input  logic [DATA_W-1:0]     req_operand_b,
   input  logic                  rsp_valid,
   input  logic [DATA_W-1:0]     rsp_result,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    pending
);

   logic [KIND_W-1:0] active_kind;
   logic [DATA_W-1:0] expected_results[$];

   function automatic logic [1:0] approx_cell(input logic [KIND_W-1:0] kind, input logic a,
                                              input logic b, input logic c);
      logic s;
      logic co;
      logic x;
      x = a ^ b;
      case (kind)
         KIND_SMA: begin
            s  = c & ~x;
            co = b | (a & c);
         end
         KIND_AMA1: begin
            co = b | (a & c);
            s  = ~co;
         end
         KIND_AMA2: begin
            s  = c & (~a | b);
            co = a;
         end
         KIND_AXA2: begin
            s  = ~x;
            co = (a & b) | (x & c);
         end
         KIND_AXA3: begin
            s  = c & ~x;
            co = (a & b) | (x & c);
         end
         KIND_BUFFER: begin
            s  = a;
            co = b;
         end
         default: begin
            s  = x ^ c;
            co = (a & b) | (x & c);
         end
      endcase
      return {s, co};
   endfunction

   function automatic logic [WIDTH-1:0] ripple_chain(input logic [KIND_W-1:0] kind,
                                                     input logic [WIDTH-1:0] x,
                                                     input logic [WIDTH-1:0] y,
                                                     input logic cin);
      logic [WIDTH-1:0] sum;
      logic [1:0]       sc;
      logic             carry;
      carry = cin;
      for (int i = 0; i < WIDTH; i++) begin
         sc     = approx_cell(kind, x[i], y[i], carry);
         sum[i] = sc[1];
         carry  = sc[0];
      end
      return sum;
   endfunction

   function automatic logic [DATA_W-1:0] predict_result(input logic [KIND_W-1:0] kind,
                                                        input logic [CMD_W-1:0] cmd,
                                                        input logic [DATA_W-1:0] a,
                                                        input logic [DATA_W-1:0] b);
      logic [WIDTH-1:0] x;
      logic [WIDTH-1:0] y;
      logic [WIDTH-1:0] diff;
      x = WIDTH'(a);
      y = WIDTH'(b);
      case (cmd)
         CMD_ADD: return DATA_W'(ripple_chain(kind, x, y, 1'b0));
         CMD_SUB: return DATA_W'(ripple_chain(kind, x, ~y, 1'b1));
         CMD_GT: begin
            diff = ripple_chain(kind, x, ~y, 1'b1);
            return {{(DATA_W-1){1'b0}}, ~diff[WIDTH-1]};
         end
         default: return '0;
      endcase
   endfunction

   task automatic note_mismatch(input string what, input logic [CSR_DATA_W-1:0] want,
                                input logic [CSR_DATA_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch on %s: expected %0h, actual %0h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (reset) begin
         expected_results.delete();
         active_kind    = KIND_EXACT;
         mismatch_count = 0;
         pending        = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               note_mismatch("result with no transaction pending", '0, rsp_result);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result !== want)
                  note_mismatch("result", want, rsp_result);
            end
         end
         if (start && !busy)
            expected_results.push_back(predict_result(active_kind, req_cmd, req_operand_a,
                                                      req_operand_b));
         if (psel && penable && pready && paddr[CSR_ADDR_W-1] == REG_CELL_KIND) begin
            if (pwrite)
               active_kind = pwdata[KIND_W-1:0];
            else if (prdata !== {{(CSR_DATA_W-KIND_W){1'b0}}, active_kind})
               note_mismatch("cell_kind read", {{(CSR_DATA_W-KIND_W){1'b0}}, active_kind},
                             prdata);
         end
         pending = expected_results.size();
      end
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
   import arasc_pkg::*;

   localparam int unsigned WIDTH = 8;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CELL_KIND_ADDR = {REG_CELL_KIND, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic [DATA_W-1:0]     req_operand_a = '0;
   logic [DATA_W-1:0]     req_operand_b = '0;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [DATA_W-1:0]     rsp_result;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    pending;
   int                    cycle_count = 0;
   int                    burst_left = 0;

   logic [DATA_W-1:0] corner_a [6] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h5A, 8'hAA};
   logic [DATA_W-1:0] corner_b [6] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'h55};
   logic [CMD_W-1:0]  corner_cmd [4] = '{CMD_ADD, CMD_SUB, CMD_GT, CMD_UNUSED};
   logic [KIND_W-1:0] phase_kind [PHASES] = '{KIND_SMA, KIND_AMA1, KIND_AMA2, KIND_AXA2,
                                              KIND_AXA3, KIND_BUFFER, KIND_EXACT,
                                              KIND_UNUSED, KIND_SMA, KIND_EXACT};

   approx_ripple_add_sub_compare #(.WIDTH(WIDTH)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_result    (rsp_result),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   ripple_result_checker #(.WIDTH(WIDTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .rsp_valid      (rsp_valid),
      .rsp_result     (rsp_result),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_transaction(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] a,
                                   input logic [DATA_W-1:0] b, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_cmd       <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (busy);
   endtask

   // drain every pending result
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [KIND_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= CELL_KIND_ADDR;
      pwdata  <= {{(CSR_DATA_W-KIND_W){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return DATA_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd();
      int r;
      r = $urandom_range(0, 15);
      if (r < 5) return CMD_ADD;
      if (r < 10) return CMD_SUB;
      if (r < 15) return CMD_GT;
      return CMD_UNUSED;
   endfunction

   initial begin
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_cmd[c])
         foreach (corner_a[p])
            send_transaction(corner_cmd[c], corner_a[p], corner_b[p], (p % 2) * 3);

      phase_kind[8] = KIND_W'($urandom_range(0, 7));
      phase_kind[9] = KIND_W'($urandom_range(0, 7));
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         csr_access(1'b1, phase_kind[ph]);
         csr_access(1'b0, '0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) == 0)
               wait_idle();
            a = pick_operand();
            b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
            send_transaction(pick_cmd(), a, b, next_gap());
         end
      end

      wait_idle();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
